// ----- rtl/bfl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the binary 3x3 lookup image filter.
package bfl_pkg;

	// Default frame limits
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	// Geometry compare width, holds any limit up to 4096 plus margin
	localparam int GEOM_W = 13;
	localparam int CFG_W  = 9;

	// Lookup table organization
	localparam int TBL_WORDS  = 8;
	localparam int TBL_IDX_W  = 3;
	localparam int TBL_WORD_W = 64;
	localparam int WIN_W      = 9;

	// Lit pixel counter
	localparam int LIT_W = 17;
	localparam logic [LIT_W-1:0] LIT_MAX = 17'd65536;

	// APB configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Item kinds
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_PIXEL = 2'd0;
	localparam kind_t KIND_FLUSH = 2'd1;
	localparam kind_t KIND_TABLE = 2'd2;

	// Register indexes
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_FRAME_WIDTH  = 2'd0;
	localparam reg_idx_t REG_FRAME_HEIGHT = 2'd1;
	localparam reg_idx_t REG_BACKGROUND   = 2'd2;

endpackage

// ----- rtl/bfl_in_if.sv -----
`timescale 1ns / 1ps
// Input item channel of the binary 3x3 lookup image filter.
interface bfl_in_if import bfl_pkg::*; ();
	logic                       valid;
	logic                       ready;
	kind_t                      kind;
	logic                       pixel_in;
	logic [TBL_IDX_W-1:0]       table_index;
	logic [TBL_WORD_W-1:0]      table_word;

	modport source (output valid, kind, pixel_in, table_index, table_word, input ready);
	modport sink (input valid, kind, pixel_in, table_index, table_word, output ready);
endinterface

// ----- rtl/bfl_out_if.sv -----
`timescale 1ns / 1ps
// Result channel of the binary 3x3 lookup image filter.
interface bfl_out_if import bfl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             pixel_out;
	logic             last_of_frame;
	logic [LIT_W-1:0] lit_count;
	logic             background_out;

	modport source (output valid, pixel_out, last_of_frame, lit_count, background_out,
		input ready);
	modport sink (input valid, pixel_out, last_of_frame, lit_count, background_out,
		output ready);
endinterface

// ----- rtl/bfl_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module bfl_ram #(
	parameter int WIDTH  = 1,
	parameter int DEPTH  = 2,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns old data on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/binary_3x3_lut_image_filter_unit.sv -----
`timescale 1ns / 1ps
// Binary 3x3 neighborhood lookup filter, top level.
//
// Items enter on the item channel (valid/ready): frame pixels in raster order,
// flush ticks, and 64-bit lookup table word writes. Filtered pixels leave on the
// result channel (valid/ready), lagging the input stream by one row plus one
// pixel; flush ticks push the last row out. The final result of a frame carries
// last_of_frame, the saturating lit count and the background for the next pass.
// The user must set geometry and background over the APB port only while the
// block is idle; the block does not enforce it. Throughput is one item per cycle
// unless the receiver stalls: a line memory read is issued when a pixel or flush
// tick is accepted, the window, table lookup and write-back follow from the
// window stage registers, and the result sits in an output register. A one-entry
// forward register covers a same-column write-back followed at once by a read
// (one-pixel-wide frames). After reset the line memory is swept to zero with
// item ready low; APB writes are taken throughout. A stalled receiver holds the
// result register, then the window stage, and then item ready drops.
module binary_3x3_lut_image_filter_unit import bfl_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	bfl_in_if.sink             item,
	bfl_out_if.source          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
	localparam int LINE_W = 2;

	function automatic logic [WIN_W-1:0] shift_in(input logic [WIN_W-1:0] w,
		input logic t, input logic m, input logic b);
		shift_in = {w[7:6], t, w[4:3], m, w[1:0], b};
	endfunction

	// Configuration registers
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic             background_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_W'(100);
			frame_height_q <= CFG_W'(100);
			background_q   <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_FRAME_WIDTH:  frame_width_q  <= pwdata[CFG_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= pwdata[CFG_W-1:0];
				REG_BACKGROUND:   background_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_q);
			REG_BACKGROUND:   prdata = PDATA_W'(background_q);
			default:          prdata = '0;
		endcase
	end

	// Clamped geometry
	logic [GEOM_W-1:0] w_raw, h_raw, w_cl, h_cl;

	always_comb begin
		w_raw = GEOM_W'(frame_width_q);
		h_raw = GEOM_W'(frame_height_q);
		if (w_raw == '0) begin
			w_cl = GEOM_W'(1);
		end else if (w_raw > GEOM_W'(MAX_WIDTH)) begin
			w_cl = GEOM_W'(MAX_WIDTH);
		end else begin
			w_cl = w_raw;
		end
		if (h_raw == '0) begin
			h_cl = GEOM_W'(1);
		end else if (h_raw > GEOM_W'(MAX_HEIGHT)) begin
			h_cl = GEOM_W'(MAX_HEIGHT);
		end else begin
			h_cl = h_raw;
		end
	end

	// Handshake and item decode
	logic in_fire, pix_fire, tbl_fire;
	logic s1_valid_q, s1_adv;
	logic clr_busy_q;
	logic [COL_W-1:0] clr_q;

	assign item.ready = !clr_busy_q && (!s1_valid_q || s1_adv);
	assign in_fire    = item.valid & item.ready;
	assign pix_fire   = in_fire & (item.kind == KIND_PIXEL || item.kind == KIND_FLUSH);
	assign tbl_fire   = in_fire & (item.kind == KIND_TABLE);

	// Stream position and per-pixel decisions
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [GEOM_W-1:0] col_ext, row_ext;
	logic top_en, mid_en, bot, emit, last, wrap;

	always_comb begin
		col_ext = GEOM_W'(col_q);
		row_ext = GEOM_W'(row_q);
		top_en  = (row_ext >= GEOM_W'(2)) && (row_ext < h_cl + GEOM_W'(2));
		mid_en  = (row_ext >= GEOM_W'(1)) && (row_ext < h_cl + GEOM_W'(1));
		bot     = (item.kind == KIND_PIXEL && row_ext < h_cl) ? item.pixel_in : background_q;
		emit    = (row_ext >= GEOM_W'(2)) || (row_ext == GEOM_W'(1) && col_q != '0);
		last    = row_ext >= h_cl + GEOM_W'(1);
		wrap    = col_ext + GEOM_W'(1) >= w_cl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_fire) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Lookup table words, loaded by table items
	logic [TBL_WORD_W-1:0] table_q [TBL_WORDS];

	always_ff @(posedge clk) begin
		if (tbl_fire) begin
			table_q[item.table_index] <= item.table_word;
		end
	end

	// Window stage registers
	logic [COL_W-1:0] col_s1;
	logic top_en_s1, mid_en_s1, bot_s1, emit_s1, last_s1, first_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pix_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			col_s1    <= col_q;
			top_en_s1 <= top_en;
			mid_en_s1 <= mid_en;
			bot_s1    <= bot;
			emit_s1   <= emit;
			last_s1   <= last;
			first_s1  <= (col_q == '0);
		end
	end

	// Line memory sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
		end else if (clr_busy_q) begin
			if (clr_q == COL_W'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Line memory: bit 1 upper row, bit 0 middle row
	logic              ram_we;
	logic [COL_W-1:0]  ram_waddr;
	logic [LINE_W-1:0] ram_wdata, ram_rdata, line_rd;
	logic              fwd_valid_q;
	logic [COL_W-1:0]  fwd_addr_q;
	logic [LINE_W-1:0] fwd_data_q;

	bfl_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (pix_fire),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	// latest write wins over a read that was issued alongside it
	assign line_rd = (fwd_valid_q && fwd_addr_q == col_s1) ? fwd_data_q : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (ram_we) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			fwd_addr_q <= ram_waddr;
			fwd_data_q <= ram_wdata;
		end
	end

	// Window, lookup and write-back
	logic [WIN_W-1:0] win_q, win_nxt, out_win;
	logic [LIT_W-1:0] lit_q, lit_nxt;
	logic top, mid, lut_bit, bg_bit;
	logic out_valid_q;

	assign s1_adv = s1_valid_q && (!emit_s1 || !out_valid_q || result.ready);

	always_comb begin
		top = top_en_s1 ? line_rd[1] : background_q;
		mid = mid_en_s1 ? line_rd[0] : background_q;
		if (first_s1) begin
			out_win = shift_in(win_q, background_q, background_q, background_q);
			win_nxt = shift_in({WIN_W{background_q}}, top, mid, bot_s1);
		end else begin
			win_nxt = shift_in(win_q, top, mid, bot_s1);
			out_win = win_nxt;
		end
		lut_bit = table_q[out_win[8:6]][out_win[5:0]];
		bg_bit  = background_q ? table_q[TBL_WORDS-1][TBL_WORD_W-1] : table_q[0][0];
		lit_nxt = (lut_bit && lit_q < LIT_MAX) ? lit_q + 1'b1 : lit_q;
		ram_we  = clr_busy_q | s1_adv;
		if (clr_busy_q) begin
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_waddr = col_s1;
			ram_wdata = {line_rd[0], bot_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			lit_q <= '0;
		end else if (s1_adv) begin
			if (last_s1) begin
				win_q <= '0;
				lit_q <= '0;
			end else begin
				win_q <= win_nxt;
				if (emit_s1) begin
					lit_q <= lit_nxt;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			result.pixel_out      <= lut_bit;
			result.last_of_frame  <= last_s1;
			result.lit_count      <= lit_nxt;
			result.background_out <= bg_bit;
		end
	end

	assign result.valid = out_valid_q;

endmodule

// ----- dv/tb_binary_3x3_lut_image_filter_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the binary 3x3 lookup filter: directed and random frames.
module tb_binary_3x3_lut_image_filter_unit;
	import bfl_pkg::*;

	localparam int MAX_W = DEF_MAX_WIDTH;
	localparam int MAX_H = DEF_MAX_HEIGHT;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 130;
	localparam kind_t KIND_UNUSED = 2'd3;

	typedef struct packed {
		kind_t                 kind;
		logic                  pixel;
		logic [TBL_IDX_W-1:0]  index;
		logic [TBL_WORD_W-1:0] word;
	} filter_item_t;

	typedef struct packed {
		logic             pixel;
		logic             last;
		logic [LIT_W-1:0] lit;
		logic             bg;
	} filtered_pixel_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	bfl_in_if  item_if ();
	bfl_out_if result_if ();

	binary_3x3_lut_image_filter_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_if),
		.result  (result_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow of the configuration registers
	int unsigned cfg_width  = 100;
	int unsigned cfg_height = 100;
	bit          cfg_bg     = 1'b0;

	// Predictor state
	bit                    line_above [MAX_W];
	bit                    line_mid [MAX_W];
	bit [WIN_W-1:0]        win;
	logic [TBL_WORD_W-1:0] lut_words [TBL_WORDS];
	int unsigned           in_col;
	int unsigned           in_row;
	logic [LIT_W-1:0]      lit_run = '0;

	filtered_pixel_t pending_pixels [$];

	int unsigned items_accepted;
	int unsigned ignored_items;
	int unsigned pixels_checked;
	int unsigned frames_seen;
	int unsigned mismatches;
	int unsigned hold_request;
	bit          steady;

	// Window shift: columns move left, the new right column comes in
	function automatic bit [WIN_W-1:0] shift_window(bit [WIN_W-1:0] w, bit t, bit m, bit b);
		return ((w << 1) & 9'h1B6) | {2'b00, t, 2'b00, m, 2'b00, b};
	endfunction

	function automatic bit lut_bit(bit [WIN_W-1:0] idx);
		return lut_words[idx[8:6]][idx[5:0]];
	endfunction

	// Advance the stream by one item; returns 1 when a filtered pixel comes out
	function automatic bit predict_filtered_pixel(input filter_item_t it,
			output filtered_pixel_t px);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		bit bgb;
		bit top;
		bit mid;
		bit bot;
		bit hit;
		bit emit;
		bit last;
		bit [WIN_W-1:0] outwin;
		px = '0;
		if (it.kind == KIND_TABLE) begin
			lut_words[it.index] = it.word;
			return 1'b0;
		end
		if (it.kind == KIND_UNUSED)
			return 1'b0;
		w = cfg_width;
		h = cfg_height;
		if (w < 1) w = 1;
		if (w > MAX_W) w = MAX_W;
		if (h < 1) h = 1;
		if (h > MAX_H) h = MAX_H;
		bgb = cfg_bg;
		r = in_row;
		c = in_col;

		// Pixels outside the frame read as background
		bot = (it.kind == KIND_PIXEL && r < h) ? it.pixel : bgb;
		top = bgb;
		mid = bgb;
		if (r >= 2 && r - 2 < h) top = line_above[c];
		if (r >= 1 && r - 1 < h) mid = line_mid[c];
		line_above[c] = line_mid[c];
		line_mid[c] = bot;

		// Column zero closes the previous row's last window
		if (c == 0) begin
			outwin = shift_window(win, bgb, bgb, bgb);
			win = shift_window(bgb ? 9'h1FF : 9'h000, top, mid, bot);
		end else begin
			win = shift_window(win, top, mid, bot);
			outwin = win;
		end

		emit = (r >= 2) || (r == 1 && c >= 1);
		last = (r >= h + 1);
		if (emit) begin
			hit = lut_bit(outwin);
			if (hit && lit_run < LIT_MAX) lit_run++;
			px.pixel = hit;
			px.last = last;
			px.lit = lit_run;
			px.bg = lut_bit(bgb ? 9'h1FF : 9'h000);
		end

		// Position update
		if (last) begin
			in_row = 0;
			in_col = 0;
			lit_run = '0;
			win = '0;
		end else if (c + 1 >= w) begin
			in_col = 0;
			if (in_row < 511) in_row++;
		end else begin
			in_col = (c + 1) & 8'hFF;
		end
		return emit;
	endfunction

	// Table word that passes the center pixel through unchanged
	function automatic logic [TBL_WORD_W-1:0] center_pass_word(int unsigned i);
		logic [TBL_WORD_W-1:0] word;
		for (int k = 0; k < TBL_WORD_W; k++)
			word[k] = 1'(((i * 64 + k) >> 4) & 1);
		return word;
	endfunction

	function automatic filter_item_t random_item(kind_t k);
		filter_item_t it;
		it.kind = k;
		it.pixel = 1'($urandom_range(1));
		it.index = TBL_IDX_W'($urandom_range(TBL_WORDS - 1));
		it.word = {$urandom, $urandom};
		return it;
	endfunction

	// Offer one item and wait until it is taken
	task automatic send_item(input filter_item_t it);
		filtered_pixel_t px;
		if (!steady) begin
			while ($urandom_range(99) < 6) begin
				item_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_if.valid       <= 1'b1;
		item_if.kind        <= it.kind;
		item_if.pixel_in    <= it.pixel;
		item_if.table_index <= it.index;
		item_if.table_word  <= it.word;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
		items_accepted++;
		if (it.kind == KIND_UNUSED) ignored_items++;
		if (predict_filtered_pixel(it, px)) pending_pixels.push_back(px);
	endtask

	task automatic send_pixel(bit v);
		filter_item_t it;
		it = random_item(KIND_PIXEL);
		it.pixel = v;
		send_item(it);
	endtask

	task automatic write_table_word(int unsigned i, logic [TBL_WORD_W-1:0] word);
		filter_item_t it;
		it = random_item(KIND_TABLE);
		it.index = TBL_IDX_W'(i);
		it.word = word;
		send_item(it);
	endtask

	// Push flushes (and stray pixels) until the frame closes
	task automatic finish_frame();
		do begin
			send_item(random_item(($urandom_range(3) == 0) ? KIND_PIXEL : KIND_FLUSH));
		end while (in_row != 0 || in_col != 0);
	endtask

	// Stop offering and let every expected pixel come out
	task automatic settle();
		item_if.valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, access cycle, then back to idle
	task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] val);
		// no item is offered while a register changes
		item_if.valid <= 1'b0;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_FRAME_WIDTH:  cfg_width = int'(val[CFG_W-1:0]);
			REG_FRAME_HEIGHT: cfg_height = int'(val[CFG_W-1:0]);
			REG_BACKGROUND:   cfg_bg = val[0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_geometry(int unsigned w, int unsigned h, bit bgb);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_BACKGROUND, PDATA_W'(bgb));
	endtask

	// Compare one filtered pixel with the oldest expectation
	task automatic check_pixel(filtered_pixel_t got);
		filtered_pixel_t exp;
		if (pending_pixels.size() == 0) begin
			$error("filtered pixel with nothing expected: pixel_out=%0b lit_count=%0d",
				got.pixel, got.lit);
			mismatches++;
			return;
		end
		exp = pending_pixels.pop_front();
		pixels_checked++;
		if (got.last) frames_seen++;
		if (got.pixel !== exp.pixel) begin
			$error("pixel_out: expected %0b, got %0b", exp.pixel, got.pixel);
			mismatches++;
		end
		if (got.last !== exp.last) begin
			$error("last_of_frame: expected %0b, got %0b", exp.last, got.last);
			mismatches++;
		end
		if (got.lit !== exp.lit) begin
			$error("lit_count: expected %0d, got %0d", exp.lit, got.lit);
			mismatches++;
		end
		if (got.bg !== exp.bg) begin
			$error("background_out: expected %0b, got %0b", exp.bg, got.bg);
			mismatches++;
		end
	endtask

	// Result sink: random stalls, plus a counted hold-off on request
	initial begin : result_sink
		filtered_pixel_t got;
		int unsigned hold_left;
		hold_left = 0;
		result_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_if.valid && result_if.ready) begin
				got.pixel = result_if.pixel_out;
				got.last = result_if.last_of_frame;
				got.lit = result_if.lit_count;
				got.bg = result_if.background_out;
				check_pixel(got);
			end
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= steady || ($urandom_range(99) >= 6);
			end
		end
	end

	// Every table word gets a known value before any pixel
	task automatic test_table_load();
		for (int i = 0; i < TBL_WORDS; i++)
			write_table_word(i, center_pass_word(i));
	endtask

	// 3x3 frame on a lit background with noise, an in-frame flush and a stray pixel
	task automatic test_small_frame();
		set_geometry(3, 3, 1'b1);
		send_pixel(1'b1);
		send_pixel(1'b0);
		send_pixel(1'b1);
		send_item(random_item(KIND_UNUSED));
		send_item(random_item(KIND_FLUSH));
		send_pixel(1'b1);
		send_pixel(1'b1);
		send_pixel(1'b0);
		send_pixel(1'b1);
		send_pixel(1'b0);
		send_pixel(1'b1);
		finish_frame();
		settle();
	endtask

	// Zero geometry acts as 1x1; width above the limit acts as the limit
	task automatic test_geometry_clamp();
		set_geometry(0, 0, 1'b0);
		send_pixel(1'b1);
		finish_frame();
		settle();
		set_geometry(300, 1, 1'b1);
		while (in_row < 1) send_pixel(1'($urandom_range(1)));
		finish_frame();
		settle();
	endtask

	// Narrow the frame while it is half sent
	task automatic test_width_change_mid_frame();
		set_geometry(5, 3, 1'b0);
		repeat (7) send_pixel(1'($urandom_range(1)));
		settle();
		write_reg(REG_FRAME_WIDTH, 2);
		while (in_row < 3) send_pixel(1'($urandom_range(1)));
		finish_frame();
		settle();
	endtask

	// Receiver holds off long enough for the block to stall its input
	task automatic test_output_backpressure();
		set_geometry(16, 6, 1'b0);
		hold_request = 300;
		while (in_row < 6) send_pixel(1'($urandom_range(1)));
		finish_frame();
		settle();
	endtask

	// Random frames: mostly well formed, some cut short, with noise and table rewrites
	task automatic test_random_frames();
		int unsigned start;
		int unsigned w;
		int unsigned h;
		int unsigned density;
		int unsigned roll;
		bit cut;
		start = items_accepted - ignored_items;
		while (items_accepted - ignored_items - start < RANDOM_ITEMS) begin
			if ($urandom_range(15) == 0) begin
				w = $urandom_range(13, 40);
				h = 1;
			end else begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 8);
			end
			set_geometry(w, h, 1'($urandom_range(1)));
			case ($urandom_range(3))
				0: for (int i = 0; i < TBL_WORDS; i++)
					write_table_word(i, center_pass_word(i));
				1: send_item(random_item(KIND_TABLE));
				default: ;
			endcase
			density = $urandom_range(100);
			cut = ($urandom_range(7) == 0);
			while (in_row < h) begin
				roll = $urandom_range(99);
				if (cut && roll < 4) break;
				if (roll < 3)
					send_item(random_item(KIND_UNUSED));
				else if (roll < 6)
					send_item(random_item(KIND_TABLE));
				else if (roll < 9)
					send_item(random_item(KIND_FLUSH));
				else
					send_pixel($urandom_range(99) < density);
			end
			if (in_row != 0 || in_col != 0) finish_frame();
			settle();
		end
	endtask

	// Frame on an all-ones table with no idling: every output is lit, the count climbs
	task automatic test_all_lit_frame();
		steady = 1'b1;
		for (int i = 0; i < TBL_WORDS; i++)
			write_table_word(i, '1);
		set_geometry(16, 8, 1'b0);
		while (in_row < 8) send_pixel(1'($urandom_range(1)));
		finish_frame();
		settle();
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.kind = KIND_PIXEL;
		item_if.pixel_in = 1'b0;
		item_if.table_index = '0;
		item_if.table_word = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_request = 0;
		steady = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_load();
		test_small_frame();
		test_geometry_clamp();
		test_width_change_mid_frame();
		test_output_backpressure();
		test_random_frames();
		test_all_lit_frame();
		settle();

		$display("Run covered %0d items, %0d filtered pixels checked over %0d frames.",
			items_accepted, pixels_checked, frames_seen);
		$display("Included clamped geometry, a mid-frame width change, a long output stall"
			, " and a fully lit frame.");
		if (mismatches == 0) begin
			$display("tb_binary_3x3_lut_image_filter_unit passed");
		end else begin
			$display("tb_binary_3x3_lut_image_filter_unit failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#400000;
		$display("tb_binary_3x3_lut_image_filter_unit failed");
		$finish;
	end

endmodule
